@@ design/ibmw_pkg.sv @@
// Shared constants, types and the control store for the inode block map walker.
package ibmw_pkg;

  // Map geometry (ENTRIES_PER_BLOCK is a power of two; the split is a shift)
  localparam int DIRECT_SLOTS      = 10;
  localparam int ENTRIES_PER_BLOCK = 128;
  localparam int SLOT_COUNT        = 13;

  localparam int ENTRY_BITS = $clog2(ENTRIES_PER_BLOCK);
  localparam int OFF_W      = 3 * ENTRY_BITS;
  localparam int SH_W       = $clog2(OFF_W);
  localparam int SLOT_AW    = $clog2(SLOT_COUNT);
  localparam int IDX_MIN_W  = $clog2(DIRECT_SLOTS + 3);
  localparam int IDX_W      = (IDX_MIN_W > SLOT_AW) ? IDX_MIN_W : SLOT_AW;

  // Field widths
  localparam int OP_W      = 2;
  localparam int SLOT_IN_W = 4;
  localparam int VALUE_W   = 32;
  localparam int LB_W      = 31;
  localparam int SLOT_W    = 24;
  localparam int BLOCK_W   = 32;
  localparam int WORD_W    = 7;

  // Upper bounds of the direct, single, double and triple ranges
  localparam logic [31:0] BOUND0 = 32'(DIRECT_SLOTS);
  localparam logic [31:0] BOUND1 = 32'(DIRECT_SLOTS + ENTRIES_PER_BLOCK);
  localparam logic [31:0] BOUND2 = 32'(DIRECT_SLOTS + ENTRIES_PER_BLOCK
                                       + ENTRIES_PER_BLOCK * ENTRIES_PER_BLOCK);
  localparam logic [31:0] BOUND3 = 32'(DIRECT_SLOTS + ENTRIES_PER_BLOCK
                                       + ENTRIES_PER_BLOCK * ENTRIES_PER_BLOCK
                                       + ENTRIES_PER_BLOCK * ENTRIES_PER_BLOCK
                                         * ENTRIES_PER_BLOCK);

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_MAP   = 2'd1;
  localparam logic [OP_W-1:0] OP_REPLY = 2'd2;

  // Result kinds
  localparam logic KIND_FETCH  = 1'b0;
  localparam logic KIND_ANSWER = 1'b1;

  // Datapath operations
  localparam logic [3:0] DP_NOP        = 4'd0;
  localparam logic [3:0] DP_WRITE_SLOT = 4'd1;
  localparam logic [3:0] DP_CLASSIFY   = 4'd2;
  localparam logic [3:0] DP_LOAD_WALK  = 4'd3;
  localparam logic [3:0] DP_TAKE_REPLY = 4'd4;
  localparam logic [3:0] DP_EMIT_FETCH = 4'd5;
  localparam logic [3:0] DP_EMIT_FINAL = 4'd6;
  localparam logic [3:0] DP_EMIT_ZERO  = 4'd7;
  localparam logic [3:0] DP_EMIT_DIRECT = 4'd8;

  // Jump conditions
  localparam logic [3:0] COND_NEVER      = 4'd0;
  localparam logic [3:0] COND_ALWAYS     = 4'd1;
  localparam logic [3:0] COND_NO_ACCEPT  = 4'd2;
  localparam logic [3:0] COND_IS_LOAD    = 4'd3;
  localparam logic [3:0] COND_IS_MAP     = 4'd4;
  localparam logic [3:0] COND_REPLY_WALK = 4'd5;
  localparam logic [3:0] COND_OUT_RANGE  = 4'd6;
  localparam logic [3:0] COND_LEVEL0     = 4'd7;
  localparam logic [3:0] COND_DESC_END   = 4'd8;

  // Program step labels
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] ST_WAIT      = 4'd0;
  localparam logic [PC_W-1:0] ST_DISP_LOAD = 4'd1;
  localparam logic [PC_W-1:0] ST_DISP_MAP  = 4'd2;
  localparam logic [PC_W-1:0] ST_DISP_REP  = 4'd3;
  localparam logic [PC_W-1:0] ST_IGNORE    = 4'd4;
  localparam logic [PC_W-1:0] ST_LOAD      = 4'd5;
  localparam logic [PC_W-1:0] ST_CLASSIFY  = 4'd6;
  localparam logic [PC_W-1:0] ST_CHK_RANGE = 4'd7;
  localparam logic [PC_W-1:0] ST_CHK_LVL0  = 4'd8;
  localparam logic [PC_W-1:0] ST_LOAD_WALK = 4'd9;
  localparam logic [PC_W-1:0] ST_REPLY     = 4'd10;
  localparam logic [PC_W-1:0] ST_DESC      = 4'd11;
  localparam logic [PC_W-1:0] ST_FETCH     = 4'd12;
  localparam logic [PC_W-1:0] ST_FINAL     = 4'd13;
  localparam logic [PC_W-1:0] ST_ZERO      = 4'd14;
  localparam logic [PC_W-1:0] ST_DIRECT    = 4'd15;

  // One control word
  typedef struct packed {
    logic            ready;   // step takes an input transaction
    logic            emit;    // step writes the output register
    logic [3:0]      dp_op;
    logic [3:0]      cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  // Datapath command from the sequencer
  typedef struct packed {
    logic       take_in;
    logic [3:0] dp_op;
  } ctl_t;

  // Datapath status for jump conditions and stalls
  typedef struct packed {
    logic is_load;
    logic is_map;
    logic reply_walk;
    logic out_range;
    logic level0;
    logic desc_end;
    logic out_busy;
  } status_t;

  // Control store
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '0;
    unique case (pc)
      ST_WAIT:      w = '{1'b1, 1'b0, DP_NOP,         COND_NO_ACCEPT,  ST_WAIT};
      ST_DISP_LOAD: w = '{1'b0, 1'b0, DP_NOP,         COND_IS_LOAD,    ST_LOAD};
      ST_DISP_MAP:  w = '{1'b0, 1'b0, DP_NOP,         COND_IS_MAP,     ST_CLASSIFY};
      ST_DISP_REP:  w = '{1'b0, 1'b0, DP_NOP,         COND_REPLY_WALK, ST_REPLY};
      ST_IGNORE:    w = '{1'b0, 1'b0, DP_NOP,         COND_ALWAYS,     ST_WAIT};
      ST_LOAD:      w = '{1'b0, 1'b0, DP_WRITE_SLOT,  COND_ALWAYS,     ST_WAIT};
      ST_CLASSIFY:  w = '{1'b0, 1'b0, DP_CLASSIFY,    COND_NEVER,      ST_WAIT};
      ST_CHK_RANGE: w = '{1'b0, 1'b0, DP_NOP,         COND_OUT_RANGE,  ST_ZERO};
      ST_CHK_LVL0:  w = '{1'b0, 1'b0, DP_NOP,         COND_LEVEL0,     ST_DIRECT};
      ST_LOAD_WALK: w = '{1'b0, 1'b0, DP_LOAD_WALK,   COND_ALWAYS,     ST_DESC};
      ST_REPLY:     w = '{1'b0, 1'b0, DP_TAKE_REPLY,  COND_NEVER,      ST_WAIT};
      ST_DESC:      w = '{1'b0, 1'b0, DP_NOP,         COND_DESC_END,   ST_FINAL};
      ST_FETCH:     w = '{1'b0, 1'b1, DP_EMIT_FETCH,  COND_ALWAYS,     ST_WAIT};
      ST_FINAL:     w = '{1'b0, 1'b1, DP_EMIT_FINAL,  COND_ALWAYS,     ST_WAIT};
      ST_ZERO:      w = '{1'b0, 1'b1, DP_EMIT_ZERO,   COND_ALWAYS,     ST_WAIT};
      ST_DIRECT:    w = '{1'b0, 1'b1, DP_EMIT_DIRECT, COND_ALWAYS,     ST_WAIT};
    endcase
    return w;
  endfunction

endpackage

@@ design/inode_block_map_walker.sv @@
// Top level of the inode block map walker: stream ports, sequencer and datapath.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tuser: operation; tdata: slot_index, value, logical_block
//  m_*      out  m_tvalid/m_tready  tuser: kind; tdata: block_number, word_index
//
// One input transaction at a time, run by a 16-step microprogram: a slot load, an
// indirect reply or a map request runs from the accept step back to the wait step.
// Synchronous reset clears the slots, the walk state and the output register.
// A result waits in the output register; the next transaction is accepted meanwhile,
// and only an emitting step stalls while that register is still full.
module inode_block_map_walker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // [3:0] slot_index, [35:4] value, [66:36] logical_block
  input  logic [1:0]  s_tuser,   // [1:0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] block_number, [38:32] word_index
  output logic [0:0]  m_tuser    // [0] kind
);

  ibmw_pkg::ctl_t    ctl;
  ibmw_pkg::status_t status;

  logic                              out_kind;
  logic [ibmw_pkg::BLOCK_W-1:0]      out_block;
  logic [ibmw_pkg::WORD_W-1:0]       out_word;

  // control
  ibmw_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .ctl      (ctl)
  );

  // datapath
  ibmw_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .ctl              (ctl),
    .in_operation     (s_tuser),
    .in_slot_index    (s_tdata[3:0]),
    .in_value         (s_tdata[35:4]),
    .in_logical_block (s_tdata[66:36]),
    .status           (status),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready),
    .out_kind         (out_kind),
    .out_block        (out_block),
    .out_word         (out_word)
  );

  // output packing
  assign m_tdata = {1'b0, out_word, out_block};
  assign m_tuser = out_kind;

endmodule

@@ design/ibmw_sequencer.sv @@
// Microprogram sequencer: step counter, control store and conditional jumps.
module ibmw_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ibmw_pkg::status_t   status,
  output ibmw_pkg::ctl_t      ctl
);

  logic [ibmw_pkg::PC_W-1:0] pc;
  logic [ibmw_pkg::PC_W-1:0] pc_next;
  ibmw_pkg::ucode_t          uw;
  logic                      accept;
  logic                      stall;
  logic                      jump;

  assign uw       = ibmw_pkg::ucode_rom(pc);
  assign in_ready = uw.ready;
  assign accept   = in_valid & uw.ready;
  // an emitting step waits while the output register still holds a result
  assign stall    = uw.emit & status.out_busy;

  // jump condition
  always_comb begin
    unique case (uw.cond)
      ibmw_pkg::COND_NEVER:      jump = 1'b0;
      ibmw_pkg::COND_ALWAYS:     jump = 1'b1;
      ibmw_pkg::COND_NO_ACCEPT:  jump = ~accept;
      ibmw_pkg::COND_IS_LOAD:    jump = status.is_load;
      ibmw_pkg::COND_IS_MAP:     jump = status.is_map;
      ibmw_pkg::COND_REPLY_WALK: jump = status.reply_walk;
      ibmw_pkg::COND_OUT_RANGE:  jump = status.out_range;
      ibmw_pkg::COND_LEVEL0:     jump = status.level0;
      ibmw_pkg::COND_DESC_END:   jump = status.desc_end;
      default:                   jump = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    priority if (stall) begin
      pc_next = pc;
    end else if (jump) begin
      pc_next = uw.target;
    end else begin
      pc_next = pc + ibmw_pkg::PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ibmw_pkg::ST_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  // datapath command
  assign ctl.take_in = accept;
  assign ctl.dp_op   = stall ? ibmw_pkg::DP_NOP : uw.dp_op;

endmodule

@@ design/ibmw_datapath.sv @@
// Walker datapath: slot registers, range split, walk state and output register.
module ibmw_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  ibmw_pkg::ctl_t                    ctl,
  input  logic [ibmw_pkg::OP_W-1:0]         in_operation,
  input  logic [ibmw_pkg::SLOT_IN_W-1:0]    in_slot_index,
  input  logic [ibmw_pkg::VALUE_W-1:0]      in_value,
  input  logic [ibmw_pkg::LB_W-1:0]         in_logical_block,
  output ibmw_pkg::status_t                 status,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_kind,
  output logic [ibmw_pkg::BLOCK_W-1:0]      out_block,
  output logic [ibmw_pkg::WORD_W-1:0]       out_word
);

  // latched input transaction
  logic [ibmw_pkg::OP_W-1:0]      r_op;
  logic [ibmw_pkg::SLOT_IN_W-1:0] r_slot;
  logic [ibmw_pkg::VALUE_W-1:0]   r_value;
  logic [ibmw_pkg::LB_W-1:0]      r_lb;

  // inode address slots
  logic [ibmw_pkg::SLOT_W-1:0] slots [ibmw_pkg::SLOT_COUNT];

  // classification results
  logic [1:0]                   level;
  logic [ibmw_pkg::OFF_W-1:0]   rem;
  logic                         out_range;
  logic [ibmw_pkg::IDX_W-1:0]   idx;

  // walk state
  logic [1:0]                   levels_left;
  logic [ibmw_pkg::OFF_W-1:0]   offset_left;
  logic                         walking;
  logic [ibmw_pkg::BLOCK_W-1:0] desc_block;

  // combinational helpers
  logic [31:0]                  lb32;
  logic [31:0]                  prev_c;
  logic [31:0]                  diff_c;
  logic [1:0]                   level_c;
  logic                         beyond_c;
  logic [ibmw_pkg::IDX_W-1:0]   idx_c;
  logic                         out_range_c;
  logic [ibmw_pkg::SLOT_W-1:0]  slot_rd;
  logic [1:0]                   ll_dec;
  logic [ibmw_pkg::SH_W-1:0]    shamt;
  logic [ibmw_pkg::OFF_W-1:0]   off_mask;
  logic [ibmw_pkg::WORD_W-1:0]  word_c;

  // range split of the logical block
  assign lb32 = {1'b0, r_lb};
  always_comb begin
    beyond_c = 1'b0;
    priority if (lb32 < ibmw_pkg::BOUND0) begin
      level_c = 2'd0;
      prev_c  = 32'd0;
    end else if (lb32 < ibmw_pkg::BOUND1) begin
      level_c = 2'd1;
      prev_c  = ibmw_pkg::BOUND0;
    end else if (lb32 < ibmw_pkg::BOUND2) begin
      level_c = 2'd2;
      prev_c  = ibmw_pkg::BOUND1;
    end else if (lb32 < ibmw_pkg::BOUND3) begin
      level_c = 2'd3;
      prev_c  = ibmw_pkg::BOUND2;
    end else begin
      level_c  = 2'd3;
      prev_c   = ibmw_pkg::BOUND2;
      beyond_c = 1'b1;
    end
  end
  assign diff_c = lb32 - prev_c;

  // slot index: the block itself for direct, else the indirect slot of the level
  always_comb begin
    if (level_c == 2'd0) begin
      idx_c = r_lb[ibmw_pkg::IDX_W-1:0];
    end else begin
      idx_c = ibmw_pkg::IDX_W'(ibmw_pkg::DIRECT_SLOTS - 1) + ibmw_pkg::IDX_W'(level_c);
    end
  end
  assign out_range_c = beyond_c | (32'(idx_c) >= 32'(ibmw_pkg::SLOT_COUNT));

  // slot read mux
  always_comb begin
    slot_rd = '0;
    for (int i = 0; i < ibmw_pkg::SLOT_COUNT; i++) begin
      if (idx == ibmw_pkg::IDX_W'(i)) begin
        slot_rd = slots[i];
      end
    end
  end

  // one level of descent: split off the top entry index
  assign ll_dec = levels_left - 2'd1;
  always_comb begin
    unique case (ll_dec)
      2'd0:    shamt = '0;
      2'd1:    shamt = ibmw_pkg::SH_W'(ibmw_pkg::ENTRY_BITS);
      2'd2:    shamt = ibmw_pkg::SH_W'(2 * ibmw_pkg::ENTRY_BITS);
      default: shamt = '0;
    endcase
  end
  assign off_mask = (ibmw_pkg::OFF_W'(1) << shamt) - ibmw_pkg::OFF_W'(1);
  assign word_c   = ibmw_pkg::WORD_W'(offset_left >> shamt);

  // input latch
  always_ff @(posedge clk) begin
    if (ctl.take_in) begin
      r_op    <= in_operation;
      r_slot  <= in_slot_index;
      r_value <= in_value;
      r_lb    <= in_logical_block;
    end
  end

  // slot writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ibmw_pkg::SLOT_COUNT; i++) begin
        slots[i] <= '0;
      end
    end else if (ctl.dp_op == ibmw_pkg::DP_WRITE_SLOT) begin
      for (int i = 0; i < ibmw_pkg::SLOT_COUNT; i++) begin
        if (32'(r_slot) == 32'(i)) begin
          slots[i] <= r_value[ibmw_pkg::SLOT_W-1:0];
        end
      end
    end
  end

  // classification registers
  always_ff @(posedge clk) begin
    if (ctl.dp_op == ibmw_pkg::DP_CLASSIFY) begin
      level     <= level_c;
      rem       <= diff_c[ibmw_pkg::OFF_W-1:0];
      out_range <= out_range_c;
      idx       <= idx_c;
    end
  end

  // walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      levels_left <= '0;
      offset_left <= '0;
      walking     <= 1'b0;
    end else begin
      unique case (ctl.dp_op)
        ibmw_pkg::DP_CLASSIFY, ibmw_pkg::DP_EMIT_FINAL: begin
          levels_left <= '0;
          offset_left <= '0;
          walking     <= 1'b0;
        end
        ibmw_pkg::DP_LOAD_WALK: begin
          levels_left <= level;
          offset_left <= rem;
        end
        ibmw_pkg::DP_EMIT_FETCH: begin
          levels_left <= ll_dec;
          offset_left <= offset_left & off_mask;
          walking     <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // block to descend from
  always_ff @(posedge clk) begin
    unique case (ctl.dp_op)
      ibmw_pkg::DP_LOAD_WALK:  desc_block <= ibmw_pkg::BLOCK_W'(slot_rd);
      ibmw_pkg::DP_TAKE_REPLY: desc_block <= r_value;
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      unique case (ctl.dp_op)
        ibmw_pkg::DP_EMIT_FETCH, ibmw_pkg::DP_EMIT_FINAL,
        ibmw_pkg::DP_EMIT_ZERO, ibmw_pkg::DP_EMIT_DIRECT: out_valid <= 1'b1;
        default: begin
          if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.dp_op)
      ibmw_pkg::DP_EMIT_FETCH: begin
        out_kind  <= ibmw_pkg::KIND_FETCH;
        out_block <= desc_block;
        out_word  <= word_c;
      end
      ibmw_pkg::DP_EMIT_FINAL: begin
        out_kind  <= ibmw_pkg::KIND_ANSWER;
        out_block <= desc_block;
        out_word  <= '0;
      end
      ibmw_pkg::DP_EMIT_ZERO: begin
        out_kind  <= ibmw_pkg::KIND_ANSWER;
        out_block <= '0;
        out_word  <= '0;
      end
      ibmw_pkg::DP_EMIT_DIRECT: begin
        out_kind  <= ibmw_pkg::KIND_ANSWER;
        out_block <= ibmw_pkg::BLOCK_W'(slot_rd);
        out_word  <= '0;
      end
      default: begin
      end
    endcase
  end

  // status to the sequencer
  assign status.is_load    = (r_op == ibmw_pkg::OP_LOAD);
  assign status.is_map     = (r_op == ibmw_pkg::OP_MAP);
  assign status.reply_walk = (r_op == ibmw_pkg::OP_REPLY) & walking;
  assign status.out_range  = out_range;
  assign status.level0     = (level == 2'd0);
  assign status.desc_end   = (desc_block == '0) | (levels_left == 2'd0);
  assign status.out_busy   = out_valid & ~out_ready;

  // answers never carry an entry index
  a_answer_word_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == ibmw_pkg::KIND_ANSWER) |-> (out_word == '0))
    else $error("answer carries a nonzero word index");

  // a fetch never points at a hole
  a_fetch_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == ibmw_pkg::KIND_FETCH) |-> (out_block != '0))
    else $error("fetch request for block zero");

  // during a walk the remaining offset fits the levels still to go
  a_offset_fits: assert property (@(posedge clk) disable iff (rst)
    walking |-> ((offset_left >> (ibmw_pkg::ENTRY_BITS * levels_left)) == '0))
    else $error("remaining offset exceeds the levels left");

endmodule

@@ tb/tb_inode_block_map_walker.sv @@
// Testbench for the inode block map walker: directed table plus random walks, checked in order.
module tb_inode_block_map_walker;
  timeunit 1ns;
  timeprecision 1ps;

  // Unused operation code, never named by the package
  localparam logic [ibmw_pkg::OP_W-1:0] OP_SPARE = 2'd3;

  // First logical block of each range, and the end of the triple range
  localparam int unsigned EPB       = ibmw_pkg::ENTRIES_PER_BLOCK;
  localparam int unsigned LB_SINGLE = ibmw_pkg::DIRECT_SLOTS;
  localparam int unsigned LB_DOUBLE = LB_SINGLE + EPB;
  localparam int unsigned LB_TRIPLE = LB_DOUBLE + EPB * EPB;
  localparam int unsigned LB_END    = LB_TRIPLE + EPB * EPB * EPB;
  localparam int unsigned LB_MAX    = 32'h7FFF_FFFF;

  localparam int unsigned RANDOM_ITEMS   = 1550;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned REPORT_MAX     = 10;

  typedef struct packed {
    logic                         kind;
    logic [ibmw_pkg::BLOCK_W-1:0] block;
    logic [ibmw_pkg::WORD_W-1:0]  word;
  } map_result_t;

  // Where the expectation of a table row comes from
  typedef enum logic [1:0] {EXP_PREDICTED, EXP_NONE, EXP_GIVEN} exp_src_t;

  typedef struct {
    logic [ibmw_pkg::OP_W-1:0]      op;
    logic [ibmw_pkg::SLOT_IN_W-1:0] slot;
    logic [ibmw_pkg::VALUE_W-1:0]   value;
    logic [ibmw_pkg::LB_W-1:0]      lb;
    exp_src_t                       source;
    map_result_t                    given;
  } map_stim_t;

  localparam map_result_t NO_RESULT   = '0;
  localparam map_result_t ZERO_ANSWER = '{ibmw_pkg::KIND_ANSWER, 32'd0, 7'd0};

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;   // [3:0] slot_index, [35:4] value, [66:36] logical_block
  logic [1:0]  s_tuser;   // [1:0] operation
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // [31:0] block_number, [38:32] word_index
  logic [0:0]  m_tuser;   // [0] kind

  inode_block_map_walker u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Predictor state: the inode address map and the walk in progress
  logic [ibmw_pkg::SLOT_W-1:0] inode_slots [ibmw_pkg::SLOT_COUNT];
  int unsigned                 walk_levels;
  int unsigned                 walk_offset;
  bit                          walk_active;

  map_result_t pending_results [$];
  map_stim_t   directed_rows [$];
  int unsigned errors;
  int unsigned reported;
  int unsigned quiet_cycles;
  int unsigned out_stall;
  bit          calm;

  // Clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Descend one level from indirect block blk, or finish the walk
  function automatic map_result_t walk_down(input logic [ibmw_pkg::BLOCK_W-1:0] blk);
    map_result_t r;
    int unsigned span;
    if (blk == '0 || walk_levels == 0) begin
      walk_active = 1'b0;
      walk_levels = 0;
      walk_offset = 0;
      r = '{ibmw_pkg::KIND_ANSWER, blk, 7'd0};
    end else begin
      walk_levels--;
      span = 1;
      repeat (walk_levels) span = span * EPB;
      r = '{ibmw_pkg::KIND_FETCH, blk, 7'(walk_offset / span)};
      walk_offset = walk_offset % span;
      walk_active = 1'b1;
    end
    return r;
  endfunction

  // Apply one transaction to the predicted map; returns 1 when a result is due
  function automatic bit map_walk_predict(input logic [ibmw_pkg::OP_W-1:0] op,
                                          input logic [ibmw_pkg::SLOT_IN_W-1:0] slot,
                                          input logic [ibmw_pkg::VALUE_W-1:0] value,
                                          input logic [ibmw_pkg::LB_W-1:0] lb,
                                          output map_result_t r);
    int unsigned lbn;
    int unsigned lvl;
    int unsigned first;
    int unsigned idx;
    bit has;
    has = 1'b0;
    r = NO_RESULT;
    case (op)
      ibmw_pkg::OP_LOAD: begin
        if (slot < ibmw_pkg::SLOT_COUNT) inode_slots[slot] = value[ibmw_pkg::SLOT_W-1:0];
      end
      ibmw_pkg::OP_MAP: begin
        walk_active = 1'b0;
        walk_levels = 0;
        walk_offset = 0;
        has = 1'b1;
        lbn = lb;
        if (lbn >= LB_END) begin
          r = ZERO_ANSWER;
        end else begin
          lvl = 0;
          first = 0;
          if (lbn >= LB_SINGLE) begin lvl = 1; first = LB_SINGLE; end
          if (lbn >= LB_DOUBLE) begin lvl = 2; first = LB_DOUBLE; end
          if (lbn >= LB_TRIPLE) begin lvl = 3; first = LB_TRIPLE; end
          idx = (lvl == 0) ? lbn : ibmw_pkg::DIRECT_SLOTS + lvl - 1;
          if (idx >= ibmw_pkg::SLOT_COUNT) begin
            r = ZERO_ANSWER;
          end else if (lvl == 0) begin
            r = '{ibmw_pkg::KIND_ANSWER, 32'(inode_slots[idx]), 7'd0};
          end else begin
            walk_levels = lvl;
            walk_offset = lbn - first;
            r = walk_down(32'(inode_slots[idx]));
          end
        end
      end
      ibmw_pkg::OP_REPLY: begin
        if (walk_active) begin
          has = 1'b1;
          r = walk_down(value);
        end
      end
      default: ;
    endcase
    return has;
  endfunction

  // Gap length for either side: mostly none or short, a few long
  function automatic int unsigned idle_len();
    int unsigned pick;
    if (calm) return 0;
    pick = $urandom_range(99, 0);
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(3, 1);
    if (pick < 97) return $urandom_range(12, 4);
    return $urandom_range(40, 20);
  endfunction

  // Logical block inside one range (4 = beyond the triple range), edges favored
  function automatic logic [ibmw_pkg::LB_W-1:0] pick_block(input int unsigned lvl);
    int unsigned lo;
    int unsigned hi;
    case (lvl)
      0:       begin lo = 0;         hi = LB_SINGLE - 1; end
      1:       begin lo = LB_SINGLE; hi = LB_DOUBLE - 1; end
      2:       begin lo = LB_DOUBLE; hi = LB_TRIPLE - 1; end
      3:       begin lo = LB_TRIPLE; hi = LB_END - 1;    end
      default: begin lo = LB_END;    hi = LB_MAX;        end
    endcase
    case ($urandom_range(7, 0))
      0:       return ibmw_pkg::LB_W'(lo);
      1:       return ibmw_pkg::LB_W'(hi);
      default: return ibmw_pkg::LB_W'($urandom_range(hi, lo));
    endcase
  endfunction

  // Random item: every field random, then the operation forced
  function automatic map_stim_t rand_item(input logic [ibmw_pkg::OP_W-1:0] op);
    map_stim_t it;
    it.op     = op;
    it.slot   = ibmw_pkg::SLOT_IN_W'($urandom_range(15, 0));
    it.value  = $urandom;
    it.lb     = ibmw_pkg::LB_W'($urandom);
    it.source = EXP_PREDICTED;
    it.given  = NO_RESULT;
    return it;
  endfunction

  task automatic add_row(input logic [ibmw_pkg::OP_W-1:0] op,
                         input logic [ibmw_pkg::SLOT_IN_W-1:0] slot,
                         input logic [ibmw_pkg::VALUE_W-1:0] value,
                         input logic [ibmw_pkg::LB_W-1:0] lb,
                         input exp_src_t source, input map_result_t given);
    map_stim_t it;
    it.op     = op;
    it.slot   = slot;
    it.value  = value;
    it.lb     = lb;
    it.source = source;
    it.given  = given;
    directed_rows.push_back(it);
  endtask

  // Drive one transaction from a falling edge; record its expectation on acceptance
  task automatic send_item(input map_stim_t it);
    int unsigned gap;
    map_result_t predicted;
    bit has;
    gap = idle_len();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.op;
    s_tdata  <= {5'd0, it.lb, it.value, it.slot};
    do @(posedge clk); while (!s_tready);
    has = map_walk_predict(it.op, it.slot, it.value, it.lb, predicted);
    case (it.source)
      EXP_PREDICTED: if (has) pending_results.push_back(predicted);
      EXP_GIVEN:     pending_results.push_back(it.given);
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Indirect word as a memory would return it: mostly real, some holes
  function automatic logic [ibmw_pkg::VALUE_W-1:0] rand_word();
    case ($urandom_range(15, 0))
      0:       return '0;
      1, 2:    return ibmw_pkg::VALUE_W'($urandom_range(255, 1));
      default: return $urandom;
    endcase
  endfunction

  task automatic load_slot();
    map_stim_t it;
    it = rand_item(ibmw_pkg::OP_LOAD);
    it.slot = ibmw_pkg::SLOT_IN_W'($urandom_range(ibmw_pkg::SLOT_COUNT - 1, 0));
    if ($urandom_range(9, 0) == 0) it.value = '0;
    send_item(it);
  endtask

  // Mostly complete walks with random content, plus loads and some noise
  task automatic random_traffic();
    int unsigned counted;
    int unsigned pick;
    int unsigned lvl;
    int unsigned replies;
    map_stim_t it;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(99, 0);
      if (pick < 15) begin
        load_slot();
        counted++;
      end else if (pick < 88) begin
        pick = $urandom_range(99, 0);
        lvl = (pick < 15) ? 0 : (pick < 35) ? 1 : (pick < 60) ? 2 : (pick < 90) ? 3 : 4;
        it = rand_item(ibmw_pkg::OP_MAP);
        it.lb = pick_block(lvl);
        send_item(it);
        counted++;
        replies = (lvl > 3) ? 0 : lvl;
        // walk cut short, so the next map request abandons it
        if ($urandom_range(9, 0) == 0) replies = $urandom_range(replies, 0);
        repeat (replies) begin
          if ($urandom_range(11, 0) == 0) begin
            load_slot();
            counted++;
          end
          it = rand_item(ibmw_pkg::OP_REPLY);
          it.value = rand_word();
          send_item(it);
          counted++;
        end
      end else begin
        case ($urandom_range(2, 0))
          0: it = rand_item(OP_SPARE);
          1: it = rand_item(ibmw_pkg::OP_REPLY);
          default: begin
            it = rand_item(ibmw_pkg::OP_LOAD);
            it.slot = ibmw_pkg::SLOT_IN_W'($urandom_range(15, ibmw_pkg::SLOT_COUNT));
          end
        endcase
        send_item(it);
        counted++;
      end
    end
  endtask

  // Alternate between stretches with no idling and normal pacing
  initial begin : pacing
    calm = 1'b0;
    forever begin
      repeat ($urandom_range(300, 60)) @(posedge clk);
      calm = ($urandom_range(2, 0) == 0);
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    if (out_stall != 0) out_stall--;
    else if ($urandom_range(2, 0) == 0) out_stall = idle_len();
    m_tready <= (out_stall == 0);
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin : result_check
    map_result_t got;
    map_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tuser[0], m_tdata[31:0], m_tdata[38:32]};
      if (pending_results.size() == 0) begin
        errors++;
        if (reported < REPORT_MAX)
          $display("unexpected result: kind %0d block %h word %0d",
                   got.kind, got.block, got.word);
        reported++;
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.block !== want.block || got.word !== want.word)
        begin
          errors++;
          if (reported < REPORT_MAX)
            $display({"mismatch: expected kind %0d block %h word %0d,",
                      " got kind %0d block %h word %0d"},
                     want.kind, want.block, want.word, got.kind, got.block, got.word);
          reported++;
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Main sequence
  initial begin : stimulus
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    m_tready  = 1'b0;
    out_stall = 0;
    errors    = 0;
    reported  = 0;
    foreach (inode_slots[i]) inode_slots[i] = '0;
    walk_levels = 0;
    walk_offset = 0;
    walk_active = 1'b0;

    // after reset every slot is a hole
    add_row(ibmw_pkg::OP_MAP,   4'd0,  32'd0,         31'd0,          EXP_GIVEN, ZERO_ANSWER);
    add_row(ibmw_pkg::OP_MAP,   4'd0,  32'd0,         31'h7FFF_FFFF,  EXP_GIVEN, ZERO_ANSWER);
    // reply while idle, spare operation, load past the last slot: all silent
    add_row(ibmw_pkg::OP_REPLY, 4'd0,  32'hFFFF_FFFF, 31'd0,          EXP_NONE,  NO_RESULT);
    add_row(OP_SPARE,           4'hF,  32'hFFFF_FFFF, 31'h7FFF_FFFF,  EXP_NONE,  NO_RESULT);
    add_row(ibmw_pkg::OP_LOAD,  4'hF,  32'hFFFF_FFFF, 31'd0,          EXP_NONE,  NO_RESULT);
    // direct slots, upper address bits dropped
    add_row(ibmw_pkg::OP_LOAD,  4'd0,  32'hFFFF_FFFF, 31'd0,          EXP_NONE,  NO_RESULT);
    add_row(ibmw_pkg::OP_MAP,   4'd0,  32'd0,         31'd0,          EXP_GIVEN,
            '{ibmw_pkg::KIND_ANSWER, 32'h00FF_FFFF, 7'd0});
    add_row(ibmw_pkg::OP_LOAD,  4'd9,  32'h0012_3456, 31'd0,          EXP_NONE,  NO_RESULT);
    add_row(ibmw_pkg::OP_MAP,   4'd0,  32'd0,         31'd9,          EXP_GIVEN,
            '{ibmw_pkg::KIND_ANSWER, 32'h0012_3456, 7'd0});
    // single indirect: hole, then both ends of the range
    add_row(ibmw_pkg::OP_MAP,   4'd0,  32'd0,         31'd10,         EXP_GIVEN, ZERO_ANSWER);
    add_row(ibmw_pkg::OP_LOAD,  4'd10, 32'hFFAB_CDEF, 31'd0,          EXP_NONE,  NO_RESULT);
    add_row(ibmw_pkg::OP_MAP,   4'd0,  32'd0,         31'd137,        EXP_GIVEN,
            '{ibmw_pkg::KIND_FETCH, 32'h00AB_CDEF, 7'd127});
    add_row(ibmw_pkg::OP_REPLY, 4'd0,  32'hFFFF_FFFF, 31'd0,          EXP_GIVEN,
            '{ibmw_pkg::KIND_ANSWER, 32'hFFFF_FFFF, 7'd0});
    add_row(ibmw_pkg::OP_MAP,   4'd0,  32'd0,         31'd10,         EXP_GIVEN,
            '{ibmw_pkg::KIND_FETCH, 32'h00AB_CDEF, 7'd0});
    add_row(ibmw_pkg::OP_REPLY, 4'd0,  32'd0,         31'd0,          EXP_GIVEN, ZERO_ANSWER);
    // double indirect with a load in the middle of the walk
    add_row(ibmw_pkg::OP_LOAD,  4'd11, 32'd1,         31'd0,          EXP_NONE,  NO_RESULT);
    add_row(ibmw_pkg::OP_MAP,   4'd0,  32'd0,         31'd138,        EXP_PREDICTED, NO_RESULT);
    add_row(ibmw_pkg::OP_REPLY, 4'd0,  32'h55,        31'd0,          EXP_PREDICTED, NO_RESULT);
    add_row(ibmw_pkg::OP_LOAD,  4'd3,  32'd7,         31'd0,          EXP_NONE,  NO_RESULT);
    add_row(ibmw_pkg::OP_REPLY, 4'd0,  32'h99,        31'd0,          EXP_PREDICTED, NO_RESULT);
    // triple indirect: last block, abandoned by a new request
    add_row(ibmw_pkg::OP_LOAD,  4'd12, 32'h00FF_FFFF, 31'd0,          EXP_NONE,  NO_RESULT);
    add_row(ibmw_pkg::OP_MAP,   4'd0,  32'd0,         31'(LB_END - 1), EXP_GIVEN,
            '{ibmw_pkg::KIND_FETCH, 32'h00FF_FFFF, 7'd127});
    add_row(ibmw_pkg::OP_REPLY, 4'd0,  32'd5,         31'd0,          EXP_PREDICTED, NO_RESULT);
    add_row(ibmw_pkg::OP_MAP,   4'd0,  32'd0,         31'd3,          EXP_GIVEN,
            '{ibmw_pkg::KIND_ANSWER, 32'd7, 7'd0});
    add_row(ibmw_pkg::OP_REPLY, 4'd0,  32'd3,         31'd0,          EXP_NONE,  NO_RESULT);
    // first block past the triple range, then a full triple walk
    add_row(ibmw_pkg::OP_MAP,   4'd0,  32'd0,         31'(LB_END),    EXP_GIVEN, ZERO_ANSWER);
    add_row(ibmw_pkg::OP_MAP,   4'd0,  32'd0,         31'(LB_TRIPLE), EXP_PREDICTED, NO_RESULT);
    add_row(ibmw_pkg::OP_REPLY, 4'd0,  32'h8000_0000, 31'd0,          EXP_PREDICTED, NO_RESULT);
    add_row(ibmw_pkg::OP_REPLY, 4'd0,  32'd1,         31'd0,          EXP_PREDICTED, NO_RESULT);
    add_row(ibmw_pkg::OP_REPLY, 4'd0,  32'hFFFF_FFFF, 31'd0,          EXP_PREDICTED, NO_RESULT);

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) send_item(directed_rows[i]);
    random_traffic();
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    errors += pending_results.size();

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
